FILE: src/tioc_pkg.sv
// ----------------------------------------------------------------------------
// tioc_pkg: shared types and constants of the timed indicator controller
// Field widths, stream packing, register indexes, request kinds and the
// fixed reciprocals used by the millisecond-to-tick conversion.
// ----------------------------------------------------------------------------
package tioc_pkg;

    // Field widths
    localparam int DEV_W      = 7;   // command mask, pin_levels, device_active
    localparam int ID_W       = 3;   // device number
    localparam int TIME_W     = 32;  // on time in ms, tick count, nearest timeout
    localparam int RATE_W     = 10;  // tick_rate_hz

    // Stream packing
    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLARITY = 1'b0,
        CFG_RATE     = 1'b1
    } t_cfg_idx;

    localparam logic [DEV_W-1:0]  POL_RESET  = 7'd64;
    localparam logic [RATE_W-1:0] RATE_RESET = 10'd1000;

    // Request kinds carried in tuser; code 3 is unused and changes nothing
    typedef enum logic [IN_USER_W-1:0] {
        REQ_MASK = 2'd0,
        REQ_DEV  = 2'd1,
        REQ_TICK = 2'd2
    } t_req;

    // Command fields that travel beside the conversion pipeline
    typedef struct packed {
        t_req               req;
        logic [DEV_W-1:0]   smask;
        logic [ID_W-1:0]    dev;
        logic               tgt;
        logic               dur_nz;
        logic [TIME_W-1:0]  elapsed;
    } t_cmd;

    // floor(ms / 1000) = ((ms >> 3) * M1) >> 36, exact for every 32-bit ms
    localparam int          M1_W   = 30;
    localparam logic [M1_W-1:0] M1 = 30'd549755814;
    localparam int          M1_SH  = 36;
    localparam int          Q_W    = 23;   // quotient holds at most 4294967

    // floor(x / 1000) = ((x >> 3) * M2) >> 24, exact for every x below 2^20
    localparam int          M2_W   = 18;
    localparam logic [M2_W-1:0] M2 = 18'd134218;
    localparam int          M2_SH  = 24;
    localparam int          REM_W  = 10;   // remainder below 1000
    localparam int          X_W    = 20;   // remainder times rate
    localparam int          QR_W   = 33;   // quotient times rate

    localparam logic [15:0] MS_PER_S = 16'd1000;

endpackage

FILE: src/tioc_conv.sv
// ----------------------------------------------------------------------------
// tioc_conv: millisecond to tick conversion pipeline
// Computes floor(ms * rate / 1000), saturated to 32 bits and at least one,
// in five register stages. Command fields ride along so that items leave
// in order, one per cycle while the downstream side does not stall.
// ----------------------------------------------------------------------------
module tioc_conv
    import tioc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // upstream
    input  logic                i_valid,
    output logic                o_ready,
    input  t_cmd                i_cmd,
    input  logic [TIME_W-1:0]   i_ms,
    input  logic [RATE_W-1:0]   i_rate,
    // downstream
    output logic                o_valid,
    input  logic                i_ready,
    output t_cmd                o_cmd,
    output logic [TIME_W-1:0]   o_ticks
);

    localparam int NSTG = 5;
    localparam int SA   = 0;   // input register
    localparam int SB   = 1;   // quotient by 1000
    localparam int SC   = 2;   // remainder, quotient times rate
    localparam int SD   = 3;   // remainder times rate
    localparam int SE   = 4;   // fraction ticks

    logic [NSTG-1:0]            r_vld;
    logic [NSTG:0]              w_rdy;
    t_cmd                       r_cmd [NSTG];

    logic [TIME_W-1:0]          r_ms_a;
    logic [TIME_W-1:0]          r_ms_b;
    logic [Q_W-1:0]             r_q_b;
    logic [REM_W-1:0]           r_rem_c;
    logic [QR_W-1:0]            r_qr_c;
    logic [X_W-1:0]             r_x_d;
    logic [QR_W-1:0]            r_qr_d;
    logic [REM_W-1:0]           r_frac_e;
    logic [QR_W-1:0]            r_qr_e;

    logic [TIME_W-3+M1_W-1:0]   w_p1;
    logic [TIME_W-1:0]          w_q1000;
    logic [TIME_W-1:0]          w_rem;
    logic [QR_W-1:0]            w_qr;
    logic [X_W-1:0]             w_x;
    logic [X_W-3+M2_W-1:0]      w_p2;
    logic [QR_W:0]              w_sum;

    // stage ready chain: a stage loads when empty or when it moves on
    always_comb begin
        w_rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[SA];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[SA]) begin
                r_vld[SA] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // arithmetic of each stage
    assign w_p1    = {{(M1_W){1'b0}}, r_ms_a[TIME_W-1:3]}
                   * {{(TIME_W-3){1'b0}}, M1};
    assign w_q1000 = TIME_W'({{(TIME_W-Q_W){1'b0}}, r_q_b} * {16'd0, MS_PER_S});
    assign w_rem   = r_ms_b - w_q1000;
    assign w_qr    = {{(QR_W-Q_W){1'b0}}, r_q_b} * {{(QR_W-RATE_W){1'b0}}, i_rate};
    assign w_x     = {{(X_W-REM_W){1'b0}}, r_rem_c} * {{(X_W-RATE_W){1'b0}}, i_rate};
    assign w_p2    = {{(M2_W){1'b0}}, r_x_d[X_W-1:3]}
                   * {{(X_W-3){1'b0}}, M2};
    assign w_sum   = {1'b0, r_qr_e} + {{(QR_W+1-REM_W){1'b0}}, r_frac_e};

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy[SA]) begin
            r_cmd[SA] <= i_cmd;
            r_ms_a    <= i_ms;
        end
        if (w_rdy[SB]) begin
            r_cmd[SB] <= r_cmd[SA];
            r_ms_b    <= r_ms_a;
            r_q_b     <= w_p1[M1_SH +: Q_W];
        end
        if (w_rdy[SC]) begin
            r_cmd[SC] <= r_cmd[SB];
            r_rem_c   <= w_rem[REM_W-1:0];
            r_qr_c    <= w_qr;
        end
        if (w_rdy[SD]) begin
            r_cmd[SD] <= r_cmd[SC];
            r_x_d     <= w_x;
            r_qr_d    <= r_qr_c;
        end
        if (w_rdy[SE]) begin
            r_cmd[SE] <= r_cmd[SD];
            r_frac_e  <= w_p2[M2_SH +: REM_W];
            r_qr_e    <= r_qr_d;
        end
    end

    // saturate above 32 bits, never load zero ticks
    always_comb begin
        priority if (w_sum[QR_W:TIME_W] != '0) begin
            o_ticks = '1;
        end else if (w_sum[TIME_W-1:0] == '0) begin
            o_ticks = TIME_W'(1);
        end else begin
            o_ticks = w_sum[TIME_W-1:0];
        end
    end

    assign o_valid = r_vld[SE];
    assign o_cmd   = r_cmd[SE];

endmodule

FILE: src/timed_indicator_output_controller.sv
// ----------------------------------------------------------------------------
// timed_indicator_output_controller: indicator outputs with auto-off timers
// Drives NUM_DEVICES indicator outputs with per-device polarity and
// countdown timers; mask, device and tick commands in, one status out.
// ----------------------------------------------------------------------------
// The block accepts one transfer per clock while the output side does not
// stall and returns exactly one result transfer per input, in order. The
// result passes through the five-stage millisecond-to-tick conversion, the
// state update stage and the output register that also takes the minimum
// over all timers. A stalled output fills the pipeline before the input
// deasserts tready. The request kind travels in tuser: 0 sets all devices
// from the command mask and cancels all timers, 1 sets one device (device
// number), 2 advances all timers by the tick count; kind 3 changes nothing.
// The result tuser bit flags a device command that named a device at or
// above NUM_DEVICES. Registers are written through the plain write port;
// the user writes them only while no transfer is in flight, which the block
// itself does not enforce. Index 0 is the active-high polarity mask (reset
// 64), index 1 the tick rate in Hz (reset 1000).
// ----------------------------------------------------------------------------
module timed_indicator_output_controller
    import tioc_pkg::*;
#(
    parameter int NUM_DEVICES = 7
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input stream
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // [6:0] command mask, [9:7] device number, [10] on/off,
    // [42:11] on time in ms, [74:43] tick count, [79:75] zero
    input  logic [IN_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] req_type
    input  logic [IN_USER_W-1:0]    i_s_axis_tuser,
    // result stream
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // [6:0] pin_levels, [13:7] device_active, [45:14] nearest timeout, [47:46] zero
    output logic [OUT_DATA_W-1:0]   o_m_axis_tdata,
    // [0] rejected
    output logic [OUT_USER_W-1:0]   o_m_axis_tuser,
    // configuration writes
    input  logic                    i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int PW = (NUM_DEVICES > DEV_W) ? NUM_DEVICES : DEV_W;
    localparam int LV = $clog2(NUM_DEVICES);
    localparam int TW = 1 << LV;

    // configuration registers
    logic [DEV_W-1:0]           r_polarity;
    logic [RATE_W-1:0]          r_rate;

    // device state
    logic [NUM_DEVICES-1:0]     r_active;
    logic [TIME_W-1:0]          r_ticks [NUM_DEVICES];
    logic [NUM_DEVICES-1:0]     n_active;
    logic [TIME_W-1:0]          n_ticks [NUM_DEVICES];

    // pipeline control
    t_cmd                       w_in_cmd;
    logic                       w_cv_vld;
    logic                       w_cv_rdy;
    t_cmd                       w_cv_cmd;
    logic [TIME_W-1:0]          w_cv_ticks;
    logic                       w_upd;
    logic                       w_rej;
    logic                       w_dev_ok;

    logic                       r_p_vld;
    logic                       r_p_rej;
    logic                       w_o_free;
    logic                       w_p_adv;

    // result register
    logic                       r_o_vld;
    logic [DEV_W-1:0]           r_o_pin;
    logic [DEV_W-1:0]           r_o_act;
    logic [TIME_W-1:0]          r_o_tmo;
    logic                       r_o_rej;

    logic [PW-1:0]              w_act_pad;
    logic [PW-1:0]              w_lvl_pad;
    logic [PW-1:0]              w_smask_pad;
    logic [TIME_W-1:0]          w_nd [TW];
    logic [NUM_DEVICES-1:0]     w_run;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity <= POL_RESET;
            r_rate     <= RATE_RESET;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_POLARITY: r_polarity <= i_cfg_wdata[DEV_W-1:0];
                CFG_RATE:     r_rate     <= i_cfg_wdata[RATE_W-1:0];
            endcase
        end
    end

    // unpack the input transfer
    always_comb begin
        w_in_cmd.req     = t_req'(i_s_axis_tuser);
        w_in_cmd.smask   = i_s_axis_tdata[6:0];
        w_in_cmd.dev     = i_s_axis_tdata[9:7];
        w_in_cmd.tgt     = i_s_axis_tdata[10];
        w_in_cmd.dur_nz  = (i_s_axis_tdata[42:11] != '0);
        w_in_cmd.elapsed = i_s_axis_tdata[74:43];
    end

    tioc_conv u_conv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_cmd      (w_in_cmd),
        .i_ms       (i_s_axis_tdata[42:11]),
        .i_rate     (r_rate),
        .o_valid    (w_cv_vld),
        .i_ready    (w_cv_rdy),
        .o_cmd      (w_cv_cmd),
        .o_ticks    (w_cv_ticks)
    );

    // handshake between update stage, post stage and result register
    assign w_o_free = !r_o_vld || i_m_axis_tready;
    assign w_p_adv  = r_p_vld && w_o_free;
    assign w_cv_rdy = !r_p_vld || w_p_adv;
    assign w_upd    = w_cv_vld && w_cv_rdy;

    assign w_dev_ok    = ({{(TIME_W-ID_W){1'b0}}, w_cv_cmd.dev} < TIME_W'(NUM_DEVICES));
    assign w_smask_pad = PW'(w_cv_cmd.smask);

    // next device state for the item in the update stage
    always_comb begin
        n_active = r_active;
        n_ticks  = r_ticks;
        w_rej    = 1'b0;
        unique case (w_cv_cmd.req)
            REQ_MASK: begin
                n_active = w_smask_pad[NUM_DEVICES-1:0];
                for (int i = 0; i < NUM_DEVICES; i++) begin
                    n_ticks[i] = '0;
                end
            end
            REQ_DEV: begin
                if (!w_dev_ok) begin
                    w_rej = 1'b1;
                end else begin
                    for (int i = 0; i < NUM_DEVICES; i++) begin
                        if (TIME_W'(i) == {{(TIME_W-ID_W){1'b0}}, w_cv_cmd.dev}) begin
                            n_active[i] = w_cv_cmd.tgt;
                            n_ticks[i]  = (w_cv_cmd.tgt && w_cv_cmd.dur_nz)
                                        ? w_cv_ticks : '0;
                        end
                    end
                end
            end
            REQ_TICK: begin
                for (int i = 0; i < NUM_DEVICES; i++) begin
                    if (r_ticks[i] != '0) begin
                        if (w_cv_cmd.elapsed >= r_ticks[i]) begin
                            n_ticks[i]  = '0;
                            n_active[i] = 1'b0;
                        end else begin
                            n_ticks[i]  = r_ticks[i] - w_cv_cmd.elapsed;
                        end
                    end
                end
            end
            default: begin
                // unused kind: state holds
            end
        endcase
    end

    // state update and post stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            for (int i = 0; i < NUM_DEVICES; i++) begin
                r_ticks[i] <= '0;
            end
            r_p_vld  <= 1'b0;
        end else begin
            if (w_upd) begin
                r_active <= n_active;
                r_ticks  <= n_ticks;
            end
            if (w_cv_rdy) begin
                r_p_vld <= w_cv_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_p_rej <= w_rej;
        end
    end

    // pin levels after polarity, absent devices read as zero
    assign w_act_pad = PW'(r_active);
    assign w_lvl_pad = ~(w_act_pad ^ PW'(r_polarity)) & PW'({NUM_DEVICES{1'b1}});

    // nearest timeout: pairwise minimum tree, idle timers count as all ones
    always_comb begin
        for (int i = 0; i < TW; i++) begin
            w_nd[i] = '1;
        end
        for (int i = 0; i < NUM_DEVICES; i++) begin
            if (r_ticks[i] != '0) begin
                w_nd[i] = r_ticks[i];
            end
        end
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < (TW >> (l + 1)); i++) begin
                w_nd[i] = (w_nd[2*i] < w_nd[2*i+1]) ? w_nd[2*i] : w_nd[2*i+1];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_o_free) begin
            r_o_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_adv) begin
            r_o_pin <= w_lvl_pad[DEV_W-1:0];
            r_o_act <= w_act_pad[DEV_W-1:0];
            r_o_tmo <= w_nd[0];
            r_o_rej <= r_p_rej;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {2'b00, r_o_tmo, r_o_act, r_o_pin};
    assign o_m_axis_tuser  = r_o_rej;

    // running timers, for checks
    always_comb begin
        for (int i = 0; i < NUM_DEVICES; i++) begin
            w_run[i] = (r_ticks[i] != '0);
        end
    end

    // a running timer always belongs to an active device
    a_timer_implies_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_run & ~r_active) == '0)
        else $error("timer running on an inactive device");

    // a timed activation never loads zero ticks
    a_load_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd && w_cv_cmd.req == REQ_DEV && w_dev_ok && w_cv_cmd.tgt
         && w_cv_cmd.dur_nz) |-> (w_cv_ticks != '0))
        else $error("timed activation converted to zero ticks");

    // while the result is stalled and the post stage is full, state holds
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_vld && r_o_vld && !i_m_axis_tready) |=>
        ($stable(r_active) && $stable(w_run)))
        else $error("device state changed during an output stall");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for timed_indicator_output_controller
// Drives mask, device, tick and unused commands over the input stream and
// compares every status transfer with a cycle-free model of the device
// states, polarity and auto-off timers. Stalls and gaps are random on both
// streams; polarity and tick rate are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb;
    import tioc_pkg::*;

    localparam int NUM_DEV     = 7;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 275;
    localparam int IDLE_LIMIT  = 2000;
    localparam logic [IN_USER_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [NUM_DEV-1:0]   DEV_MASK   = 7'h7F;

    // Expected status of one result transfer
    typedef struct packed {
        logic [DEV_W-1:0]  pins;
        logic [DEV_W-1:0]  act;
        logic [TIME_W-1:0] tmo;
        logic              rej;
    } t_status;

    // ------------------------------------------------------------------
    // Device state predictor and queue of expected status words
    // ------------------------------------------------------------------
    class indicator_model;
        logic [DEV_W-1:0]  polarity;
        logic [RATE_W-1:0] rate_hz;
        logic [DEV_W-1:0]  active;
        logic [TIME_W-1:0] left [NUM_DEV];
        t_status           status_q [$];
        int                n_bad;
        int                n_seen;
        int                n_rej;
        int                n_kind [4];

        function new();
            polarity = POL_RESET;
            rate_hz  = RATE_RESET;
            active   = '0;
            foreach (left[i]) left[i] = '0;
            n_bad  = 0;
            n_seen = 0;
            n_rej  = 0;
            foreach (n_kind[i]) n_kind[i] = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_POLARITY: polarity = val[DEV_W-1:0];
                CFG_RATE:     rate_hz  = val[RATE_W-1:0];
                default: ;
            endcase
        endfunction

        // ms * rate / 1000, saturated to 32 bits, never below one tick
        function logic [TIME_W-1:0] ms_to_ticks(logic [TIME_W-1:0] ms);
            logic [63:0] t;
            t = ({32'd0, ms} * {54'd0, rate_hz}) / 64'd1000;
            if (t > 64'h0000_0000_FFFF_FFFF) t = 64'h0000_0000_FFFF_FFFF;
            if (t == 64'd0) t = 64'd1;
            return t[TIME_W-1:0];
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // Apply one accepted command and queue the status it produces
        function void accept_cmd(logic [IN_USER_W-1:0] req, logic [IN_DATA_W-1:0] d);
            logic [DEV_W-1:0]  smask;
            logic [ID_W-1:0]   dev;
            logic              tgt;
            logic [TIME_W-1:0] dur;
            logic [TIME_W-1:0] el;
            logic [TIME_W-1:0] best;
            t_status           s;
            smask = d[6:0];
            dev   = d[9:7];
            tgt   = d[10];
            dur   = d[42:11];
            el    = d[74:43];
            s.rej = 1'b0;
            n_kind[req]++;
            case (req)
                REQ_MASK: begin
                    active = smask & DEV_MASK;
                    foreach (left[i]) left[i] = '0;
                end
                REQ_DEV: begin
                    if (dev >= NUM_DEV) begin
                        s.rej = 1'b1;
                        n_rej++;
                    end else begin
                        active[dev] = tgt;
                        left[dev]   = (tgt && dur != 0) ? ms_to_ticks(dur) : '0;
                    end
                end
                REQ_TICK: begin
                    foreach (left[i]) begin
                        if (left[i] != 0) begin
                            if (el >= left[i]) begin
                                left[i]   = '0;
                                active[i] = 1'b0;
                            end else begin
                                left[i] = left[i] - el;
                            end
                        end
                    end
                end
                default: ;
            endcase
            best = '1;
            foreach (left[i])
                if (left[i] != 0 && left[i] < best) best = left[i];
            s.pins = ~(active ^ polarity) & DEV_MASK;
            s.act  = active;
            s.tmo  = best;
            status_q.push_back(s);
        endfunction

        // Compare one result transfer with the oldest expected status
        function void match_status(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
            t_status w;
            n_seen++;
            if (status_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("tb: result %0d arrived with nothing pending: data %h rej %b",
                             n_seen, d, u[0]);
                return;
            end
            w = status_q.pop_front();
            if (d[6:0] !== w.pins || d[13:7] !== w.act || d[45:14] !== w.tmo
                    || u[0] !== w.rej) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("tb: result %0d exp/act pins %h/%h act %h/%h tmo %h/%h rej %b/%b",
                             n_seen, w.pins, d[6:0], w.act, d[13:7],
                             w.tmo, d[45:14], w.rej, u[0]);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  o_m_axis_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    indicator_model model;
    bit             idle_on;
    int             stall_len;
    int             idle_cycles;
    int             n_cfg;

    timed_indicator_output_controller #(
        .NUM_DEVICES(NUM_DEV)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Field order in tdata: command mask, device number, on/off, duration, elapsed
    function automatic logic [IN_DATA_W-1:0] pack_cmd(logic [DEV_W-1:0] smask,
            logic [ID_W-1:0] dev, logic tgt, logic [TIME_W-1:0] dur,
            logic [TIME_W-1:0] el);
        return {5'd0, el, dur, tgt, dev, smask};
    endfunction

    // One input transfer; entered and left at a falling edge
    task automatic put_item(logic [IN_USER_W-1:0] req, logic [IN_DATA_W-1:0] d);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= req;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        model.accept_cmd(req, d);
        @(negedge i_clk);
    endtask

    // Hold the input off until every expected status has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_wen <= 1'b0;
        model.set_reg(idx, val);
        n_cfg++;
        @(negedge i_clk);
    endtask

    // Output side: random stalls while idling is enabled
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_len > 0) begin
                m_tready <= 1'b0;
                stall_len--;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 99) < 15) stall_len = gap_len();
            end
        end
    end

    // Result check and watchdog
    initial begin
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && m_tready)
                model.match_status(o_m_axis_tdata, o_m_axis_tuser);
            if ((o_m_axis_tvalid && m_tready) || (s_tvalid && o_s_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: no transfer for %0d cycles, %0d results pending",
                         IDLE_LIMIT, model.pending());
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        logic [IN_USER_W-1:0]  req;
        logic [DEV_W-1:0]      smask;
        logic [ID_W-1:0]       dev;
        logic                  tgt;
        logic [TIME_W-1:0]     dur;
        logic [TIME_W-1:0]     el;
        logic [RATE_W-1:0]     rate_tab [PHASES];
        int                    r;

        model       = new();
        idle_on     = 1'b0;
        stall_len   = 0;
        idle_cycles = 0;
        n_cfg       = 0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cfg_wen     = 1'b0;
        cfg_idx     = CFG_POLARITY;
        cfg_wdata   = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings (polarity 64, 1000 Hz)
        put_item(REQ_TICK,   pack_cmd('0, '0, 1'b0, '0, 32'd0));       // zero elapsed
        put_item(REQ_UNUSED, pack_cmd('1, '1, 1'b1, '1, '1));          // no-op kind
        put_item(REQ_MASK,   pack_cmd(7'h7F, 3'd0, 1'b0, '0, '0));
        put_item(REQ_MASK,   pack_cmd(7'h00, 3'd7, 1'b1, '1, '1));
        put_item(REQ_DEV,    pack_cmd(7'h7F, 3'd7, 1'b1, 32'd10, '0)); // bad device id
        put_item(REQ_DEV,    pack_cmd('0, 3'd0, 1'b1, 32'd0, '0));     // stays on
        put_item(REQ_DEV,    pack_cmd('0, 3'd1, 1'b1, 32'd1, '0));
        put_item(REQ_DEV,    pack_cmd('0, 3'd2, 1'b1, '1, '0));
        put_item(REQ_DEV,    pack_cmd('0, 3'd6, 1'b1, 32'd5000, '0));
        put_item(REQ_DEV,    pack_cmd('0, 3'd3, 1'b1, 32'd999, '0));
        put_item(REQ_TICK,   pack_cmd('0, '0, 1'b0, '0, 32'd1));
        put_item(REQ_DEV,    pack_cmd('0, 3'd3, 1'b0, 32'd50, '0));    // cancel timer
        put_item(REQ_DEV,    pack_cmd('0, 3'd5, 1'b1, 32'd100, '0));
        put_item(REQ_DEV,    pack_cmd('0, 3'd5, 1'b1, 32'd0, '0));     // timer off, stays on
        put_item(REQ_DEV,    pack_cmd('0, 3'd4, 1'b1, 32'd7, '0));
        put_item(REQ_TICK,   pack_cmd('0, '0, 1'b0, '0, 32'd3));
        put_item(REQ_TICK,   pack_cmd('0, '0, 1'b0, '0, '1));
        put_item(REQ_DEV,    pack_cmd('0, 3'd6, 1'b1, 32'd40, '0));
        put_item(REQ_MASK,   pack_cmd(7'h55, '0, 1'b0, '0, '0));      // cancels countdowns
        put_item(REQ_DEV,    pack_cmd('0, 3'd6, 1'b0, '0, '0));

        // Fastest rate: long durations saturate
        drain();
        write_reg(CFG_RATE, 10'd1023);
        write_reg(CFG_POLARITY, 10'd0);
        put_item(REQ_DEV,  pack_cmd('0, 3'd2, 1'b1, '1, '0));
        put_item(REQ_DEV,  pack_cmd('0, 3'd1, 1'b1, 32'd1, '0));
        put_item(REQ_TICK, pack_cmd('0, '0, 1'b0, '0, 32'd5));

        // Zero and slowest rate: short durations convert to one tick
        drain();
        write_reg(CFG_RATE, 10'd0);
        write_reg(CFG_POLARITY, 10'd127);
        put_item(REQ_DEV,  pack_cmd('0, 3'd0, 1'b1, 32'd123, '0));
        drain();
        write_reg(CFG_RATE, 10'd1);
        put_item(REQ_DEV,  pack_cmd('0, 3'd3, 1'b1, 32'd999, '0));
        put_item(REQ_DEV,  pack_cmd('0, 3'd4, 1'b1, 32'd2000, '0));
        put_item(REQ_TICK, pack_cmd('0, '0, 1'b0, '0, 32'd1));

        // Random phases, each with its own polarity and rate
        rate_tab = '{10'd1000, 10'd1, 10'd1023, 10'd0, 10'd0, 10'd0};
        rate_tab[4] = RATE_W'($urandom_range(2, 999));
        rate_tab[5] = RATE_W'($urandom_range(0, 1023));
        for (int p = 0; p < PHASES; p++) begin
            drain();
            idle_on = (p != 0 && p != 3);
            write_reg(CFG_POLARITY, (p == 0) ? 10'd0 : (p == 1) ? 10'd127
                                             : 10'($urandom_range(0, 127)));
            write_reg(CFG_RATE, rate_tab[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off until the pipeline is empty
                if (n == PHASE_ITEMS / 2) drain();
                r = $urandom_range(0, 99);
                req = (r < 8) ? REQ_MASK : (r < 50) ? REQ_DEV
                    : (r < 96) ? REQ_TICK : REQ_UNUSED;
                smask = DEV_W'($urandom_range(0, 127));
                dev   = ID_W'($urandom_range(0, 7));
                tgt   = ($urandom_range(0, 99) < 80);
                r = $urandom_range(0, 99);
                dur = (r < 10) ? 32'd0 : (r < 60) ? 32'($urandom_range(1, 40))
                    : (r < 85) ? 32'($urandom_range(41, 3000))
                    : (r < 97) ? $urandom() : '1;
                r = $urandom_range(0, 99);
                el = (r < 15) ? 32'd0 : (r < 70) ? 32'($urandom_range(1, 8))
                   : (r < 90) ? 32'($urandom_range(9, 500))
                   : (r < 98) ? $urandom() : '1;
                put_item(req, pack_cmd(smask, dev, tgt, dur, el));
            end
        end

        drain();
        idle_on = 1'b0;
        repeat (20) @(posedge i_clk);

        $display("tb: %0d results: %0d mask, %0d device (%0d rejected), %0d tick, %0d unused",
                 model.n_seen, model.n_kind[REQ_MASK], model.n_kind[REQ_DEV], model.n_rej,
                 model.n_kind[REQ_TICK], model.n_kind[REQ_UNUSED]);
        $display("tb: %0d register writes, tick rates 0 to 1023, polarity masks 0 and 127",
                 n_cfg);
        if (model.n_bad == 0 && model.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: %0d mismatches, %0d results missing", model.n_bad, model.pending());
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: timed_indicator_output_controller.f
src/tioc_pkg.sv
src/tioc_conv.sv
src/timed_indicator_output_controller.sv
tb/sv/tb.sv
